// ----- hdl/rmws_pkg.sv -----
package rmws_pkg;

  localparam int TASK_W   = 4;
  localparam int DEPTH_W  = 8;
  localparam int STATUS_W = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 4'd0,
    ST_NESTED    = 4'd1,
    ST_QUEUED    = 4'd2,
    ST_STILL     = 4'd3,
    ST_HANDED    = 4'd4,
    ST_FREED     = 4'd5,
    ST_NOT_OWNER = 4'd6,
    ST_FULL      = 4'd7,
    ST_OVERFLOW  = 4'd8
  } status_t;

endpackage

// ----- hdl/rmws_req_if.sv -----
interface rmws_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [rmws_pkg::TASK_W-1:0] task_id;

  modport source (output valid, output req_type, output task_id, input ready);
  modport sink   (input valid, input req_type, input task_id, output ready);
endinterface

// ----- hdl/rmws_rsp_if.sv -----
interface rmws_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rmws_pkg::STATUS_W-1:0] status;
  logic                         woken_valid;
  logic [rmws_pkg::TASK_W-1:0]   woken_task;
  logic                         held;
  logic [rmws_pkg::TASK_W-1:0]   holder;
  logic [rmws_pkg::DEPTH_W-1:0]  depth;

  modport source (output valid, output status, output woken_valid, output woken_task,
                  output held, output holder, output depth, input ready);
  modport sink   (input valid, input status, input woken_valid, input woken_task,
                  input held, input holder, input depth, output ready);
endinterface

// ----- hdl/recursive_mutex_with_waiter_stack.sv -----
// Channel   Dir  Word
// in_ch     in   req_type, task_id (lock or unlock request)
// out_ch    out  status, woken_valid, woken_task, held, holder, depth
//
// One request per cycle unless stalled; the owner compare and the push or pop
// of the waiter stack fit in the accepting cycle, as the stack top and the
// entry below it sit in registers, the rest in a memory. Results are registered.
// in_ch.ready is high while the result register is empty or being taken.
// Reset (rst_n low, synchronous) frees the mutex and empties the stack.
module recursive_mutex_with_waiter_stack #(
  parameter int TASK_SLOTS = 16,
  parameter int NEST_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  rmws_req_if.sink          in_ch,
  rmws_rsp_if.source        out_ch
);
  import rmws_pkg::*;

  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int IDX_W = $clog2(TASK_SLOTS);

  logic                 owner_valid_r, owner_valid_nxt;
  logic [TASK_W-1:0]    owner_task_r, owner_task_nxt;
  logic [NEST_BITS-1:0] nest_r, nest_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TASK_W-1:0]    top_r;
  logic [TASK_W-1:0]    below_r;
  logic [TASK_W-1:0]    stack_mem [TASK_SLOTS];

  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic                 woken_valid_r, woken_valid_nxt;
  logic [TASK_W-1:0]    woken_task_r, woken_task_nxt;
  logic                 held_r;
  logic [TASK_W-1:0]    holder_r;
  logic [DEPTH_W-1:0]   depth_r;

  logic                 accept;
  logic                 push;
  logic                 pop;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_idx;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wr_idx      = IDX_W'(count_r - CNT_W'(1));
  assign rd_idx      = IDX_W'(count_r - CNT_W'(3));

  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_task_nxt  = owner_task_r;
    nest_nxt        = nest_r;
    count_nxt       = count_r;
    push            = 1'b0;
    pop             = 1'b0;
    status_nxt      = ST_NOT_OWNER;
    woken_valid_nxt = 1'b0;
    woken_task_nxt  = '0;
    if (!in_ch.req_type) begin
      if (owner_valid_r && owner_task_r == in_ch.task_id) begin
        if (&nest_r) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          nest_nxt   = nest_r + NEST_BITS'(1);
          status_nxt = ST_NESTED;
        end
      end else if (!owner_valid_r) begin
        owner_valid_nxt = 1'b1;
        owner_task_nxt  = in_ch.task_id;
        nest_nxt        = NEST_BITS'(1);
        status_nxt      = ST_NEW;
      end else if (count_r == CNT_W'(TASK_SLOTS)) begin
        status_nxt = ST_FULL;
      end else begin
        push       = 1'b1;
        count_nxt  = count_r + CNT_W'(1);
        status_nxt = ST_QUEUED;
      end
    end else begin
      if (!owner_valid_r || owner_task_r != in_ch.task_id) begin
        status_nxt = ST_NOT_OWNER;
      end else if (nest_r > NEST_BITS'(1)) begin
        nest_nxt   = nest_r - NEST_BITS'(1);
        status_nxt = ST_STILL;
      end else if (count_r != '0) begin
        // hand over to the most recent waiter
        pop             = 1'b1;
        count_nxt       = count_r - CNT_W'(1);
        woken_valid_nxt = 1'b1;
        woken_task_nxt  = top_r;
        owner_task_nxt  = top_r;
        nest_nxt        = NEST_BITS'(1);
        status_nxt      = ST_HANDED;
      end else begin
        owner_valid_nxt = 1'b0;
        owner_task_nxt  = '0;
        nest_nxt        = '0;
        count_nxt       = '0;
        status_nxt      = ST_FREED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= 1'b0;
      owner_task_r  <= '0;
      nest_r        <= '0;
      count_r       <= '0;
    end else if (accept) begin
      owner_valid_r <= owner_valid_nxt;
      owner_task_r  <= owner_task_nxt;
      nest_r        <= nest_nxt;
      count_r       <= count_nxt;
    end
  end

  // stack: top_r is entry count-1, below_r entry count-2, memory holds the rest
  always_ff @(posedge clk) begin
    if (accept && push) begin
      top_r   <= in_ch.task_id;
      below_r <= top_r;
      if (count_r != '0) begin
        stack_mem[wr_idx] <= top_r;
      end
    end else if (accept && pop) begin
      top_r <= below_r;
      if (count_r >= CNT_W'(3)) begin
        below_r <= stack_mem[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      woken_valid_r <= woken_valid_nxt;
      woken_task_r  <= woken_task_nxt;
      held_r        <= owner_valid_nxt;
      holder_r      <= owner_valid_nxt ? owner_task_nxt : '0;
      depth_r       <= DEPTH_W'(nest_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.woken_valid = woken_valid_r;
  assign out_ch.woken_task  = woken_task_r;
  assign out_ch.held        = held_r;
  assign out_ch.holder      = holder_r;
  assign out_ch.depth       = depth_r;

endmodule

// ----- hdl/rmws_checker.sv -----
module rmws_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rmws_pkg::STATUS_W-1:0] status,
  input logic                         woken_valid,
  input logic [rmws_pkg::TASK_W-1:0]   woken_task,
  input logic                         held,
  input logic [rmws_pkg::TASK_W-1:0]   holder,
  input logic [rmws_pkg::DEPTH_W-1:0]  depth
);
  import rmws_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(holder))
    else $error("result word changed while stalled");

  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without an accepted request");

  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!held || status == ST_FREED) |-> !held && holder == '0 && depth == '0)
    else $error("free mutex reports an owner or depth");

  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && woken_valid |->
      status == ST_HANDED && held && holder == woken_task && depth == DEPTH_W'(1))
    else $error("handover word inconsistent");

endmodule

bind recursive_mutex_with_waiter_stack rmws_checker u_rmws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .woken_valid(out_ch.woken_valid),
  .woken_task (out_ch.woken_task),
  .held       (out_ch.held),
  .holder     (out_ch.holder),
  .depth      (out_ch.depth)
);

// ----- test/tb_recursive_mutex_with_waiter_stack.sv -----
module tb_recursive_mutex_with_waiter_stack;
  import rmws_pkg::*;

  localparam int          SLOTS          = 16;
  localparam logic [7:0]  DEPTH_TOP      = 8'hFF;
  localparam logic        REQ_LOCK       = 1'b0;
  localparam logic        REQ_UNLOCK     = 1'b1;
  localparam int          RANDOM_WORDS   = 950;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          HOLDOFF_START  = 120;
  localparam int          HOLDOFF_CYCLES = 150;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          REPORT_MAX     = 10;

  typedef struct packed {
    logic                          held;
    logic [TASK_W-1:0]             owner;
    logic [DEPTH_W-1:0]            depth;
    logic [SLOTS-1:0][TASK_W-1:0]  waiters;
    logic [4:0]                    n_waiting;
  } mutex_state_t;

  typedef struct packed {
    logic              req_type;
    logic [TASK_W-1:0] task_id;
  } mutex_req_t;

  typedef struct packed {
    status_t            status;
    logic               woken_valid;
    logic [TASK_W-1:0]  woken_task;
    logic               held;
    logic [TASK_W-1:0]  holder;
    logic [DEPTH_W-1:0] depth;
  } mutex_rsp_t;

  logic clk;
  logic rst_n = 1'b0;

  rmws_req_if req_ch();
  rmws_rsp_if rsp_ch();

  recursive_mutex_with_waiter_stack u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  mutex_req_t   pending_q[$];
  mutex_rsp_t   grant_q[$];
  mutex_state_t plan_state;
  mutex_state_t live_state;
  mutex_req_t   seen_req;
  mutex_rsp_t   seen_rsp;
  mutex_rsp_t   want_rsp;
  int           words_total;
  int           words_in;
  int           words_out;
  int           n_err;
  int           phase;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           holdoff_left;
  int           run_cycles;
  int           quiet_cycles;
  int           status_hits[9];
  bit           in_fired;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic mutex_rsp_t grant_step(inout mutex_state_t s, input mutex_req_t r);
    mutex_rsp_t o;
    status_t    st;
    o = '0;
    st = ST_NEW;
    if (r.req_type == REQ_LOCK) begin
      if (s.held && s.owner == r.task_id) begin
        if (s.depth == DEPTH_TOP) begin
          st = ST_OVERFLOW;
        end else begin
          s.depth = s.depth + 1'b1;
          st = ST_NESTED;
        end
      end else if (!s.held) begin
        s.held = 1'b1;
        s.owner = r.task_id;
        s.depth = 8'd1;
        st = ST_NEW;
      end else if (s.n_waiting >= SLOTS) begin
        st = ST_FULL;
      end else begin
        s.waiters[s.n_waiting[3:0]] = r.task_id;
        s.n_waiting = s.n_waiting + 1'b1;
        st = ST_QUEUED;
      end
    end else begin
      if (!s.held || s.owner != r.task_id) begin
        st = ST_NOT_OWNER;
      end else if (s.depth > 8'd1) begin
        s.depth = s.depth - 1'b1;
        st = ST_STILL;
      end else if (s.n_waiting > 0) begin
        s.n_waiting = s.n_waiting - 1'b1;
        o.woken_valid = 1'b1;
        o.woken_task = s.waiters[s.n_waiting[3:0]];
        s.owner = o.woken_task;
        s.depth = 8'd1;
        st = ST_HANDED;
      end else begin
        s.held = 1'b0;
        s.owner = '0;
        s.depth = '0;
        s.n_waiting = '0;
        st = ST_FREED;
      end
    end
    o.status = st;
    o.held = s.held;
    o.holder = s.held ? s.owner : '0;
    o.depth = s.depth;
    return o;
  endfunction

  function automatic void queue_request(input logic rt, input logic [TASK_W-1:0] tid);
    mutex_req_t r;
    mutex_rsp_t unused;
    r.req_type = rt;
    r.task_id = tid;
    unused = grant_step(plan_state, r);
    pending_q.push_back(r);
  endfunction

  // idle plan: none, sender idle, receiver stall, both
  always @(negedge clk) begin
    phase = (words_total > 0) ? (words_in * 4) / words_total : 0;
    if (phase > 3) phase = 3;
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_LOCK;
      req_ch.task_id <= '0;
    end else if (!req_ch.valid || in_fired) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.req_type <= pending_q[0].req_type;
        req_ch.task_id <= pending_q[0].task_id;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // hold the receiver off once while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      run_cycles = 0;
      holdoff_left = 0;
    end else begin
      run_cycles++;
      if (run_cycles == HOLDOFF_START) begin
        holdoff_left = HOLDOFF_CYCLES;
      end else if (holdoff_left > 0) begin
        holdoff_left--;
      end
    end
  end

  always @(posedge clk) begin
    in_fired = 1'b0;
    if (rst_n && req_ch.valid && req_ch.ready) begin
      seen_req.req_type = req_ch.req_type;
      seen_req.task_id = req_ch.task_id;
      grant_q.push_back(grant_step(live_state, seen_req));
      void'(pending_q.pop_front());
      words_in++;
      in_fired = 1'b1;
    end
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      seen_rsp.status = status_t'(rsp_ch.status);
      seen_rsp.woken_valid = rsp_ch.woken_valid;
      seen_rsp.woken_task = rsp_ch.woken_task;
      seen_rsp.held = rsp_ch.held;
      seen_rsp.holder = rsp_ch.holder;
      seen_rsp.depth = rsp_ch.depth;
      words_out++;
      if (grant_q.size() == 0) begin
        n_err++;
        if (n_err <= REPORT_MAX)
          $display("ERROR: result word with none expected: status=%0d", rsp_ch.status);
      end else begin
        want_rsp = grant_q.pop_front();
        if (rsp_ch.status < 9) status_hits[rsp_ch.status]++;
        if (seen_rsp.status !== want_rsp.status ||
            seen_rsp.woken_valid !== want_rsp.woken_valid ||
            seen_rsp.woken_task !== want_rsp.woken_task ||
            seen_rsp.held !== want_rsp.held ||
            seen_rsp.holder !== want_rsp.holder ||
            seen_rsp.depth !== want_rsp.depth) begin
          n_err++;
          if (n_err <= REPORT_MAX) begin
            $display("ERROR: word %0d exp status=%0d woken=%0b/%0d held=%0b holder=%0d depth=%0d",
                     words_out, want_rsp.status, want_rsp.woken_valid, want_rsp.woken_task,
                     want_rsp.held, want_rsp.holder, want_rsp.depth);
            $display("  got status=%0d woken=%0b/%0d held=%0b holder=%0d depth=%0d",
                     rsp_ch.status, rsp_ch.woken_valid, rsp_ch.woken_task, rsp_ch.held,
                     rsp_ch.holder, rsp_ch.depth);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [TASK_W-1:0] tid;
    int                pick;
    int                n_directed;
    int                n_seen;
    bit                deep_done;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOCK;
    req_ch.task_id = '0;
    rsp_ch.ready = 1'b0;
    plan_state = '0;
    live_state = '0;
    words_total = 0;
    words_in = 0;
    words_out = 0;
    n_err = 0;
    quiet_cycles = 0;
    deep_done = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;

    queue_request(REQ_UNLOCK, 4'd0);
    queue_request(REQ_LOCK, 4'd15);
    queue_request(REQ_LOCK, 4'd15);
    queue_request(REQ_UNLOCK, 4'd0);
    queue_request(REQ_UNLOCK, 4'd15);
    for (int t = 0; t < 15; t++) queue_request(REQ_LOCK, TASK_W'(t));
    queue_request(REQ_LOCK, 4'd0);
    queue_request(REQ_LOCK, 4'd9);
    queue_request(REQ_UNLOCK, 4'd15);
    n_directed = pending_q.size();

    while (pending_q.size() - n_directed < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (!deep_done && pending_q.size() - n_directed >= 300 && plan_state.held) begin
        deep_done = 1'b1;
        while (plan_state.depth != DEPTH_TOP) queue_request(REQ_LOCK, plan_state.owner);
        queue_request(REQ_LOCK, plan_state.owner);
        queue_request(REQ_LOCK, plan_state.owner);
        while (plan_state.depth > 8'd1) queue_request(REQ_UNLOCK, plan_state.owner);
      end else if (pick < 40) begin
        tid = $urandom_range(0, 15);
        if (plan_state.held && $urandom_range(0, 3) == 0) tid = plan_state.owner;
        queue_request(REQ_LOCK, tid);
      end else if (pick < 82) begin
        tid = plan_state.held ? plan_state.owner : TASK_W'($urandom_range(0, 15));
        queue_request(REQ_UNLOCK, tid);
      end else if (pick < 90) begin
        queue_request(REQ_UNLOCK, TASK_W'($urandom_range(0, 15)));
      end else if (pick < 95) begin
        repeat ($urandom_range(4, 20)) begin
          tid = plan_state.held ? plan_state.owner : TASK_W'($urandom_range(0, 15));
          queue_request(REQ_UNLOCK, tid);
        end
      end else begin
        repeat ($urandom_range(4, 18)) queue_request(REQ_LOCK, TASK_W'($urandom_range(0, 15)));
      end
    end
    words_total = pending_q.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || grant_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    n_seen = 0;
    foreach (status_hits[i]) if (status_hits[i] > 0) n_seen++;
    $display("Summary: %0d requests, %0d result words, %0d of 9 status codes hit,",
             words_in, words_out, n_seen);
    $display("  over four idle/stall phases, a full waiter stack and a nesting overflow run");
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- recursive_mutex_with_waiter_stack.f -----
hdl/rmws_pkg.sv
hdl/rmws_req_if.sv
hdl/rmws_rsp_if.sv
hdl/recursive_mutex_with_waiter_stack.sv
hdl/rmws_checker.sv
test/tb_recursive_mutex_with_waiter_stack.sv
